[rtl/ipv6tp_pkg.sv]
// Package: shared types, character codes and hex decode for the IPv6 text parser.
`timescale 1ns / 1ps

package ipv6tp_pkg;

    localparam int unsigned GROUP_COUNT = 8;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    localparam logic [7:0] OFFSET_DIGIT = 8'd48;
    localparam logic [7:0] OFFSET_UPPER = 8'd55;
    localparam logic [7:0] OFFSET_LOWER = 8'd87;

    localparam logic [3:0] GROUPS_FULL  = 4'd8;
    localparam logic [2:0] DIGITS_FULL  = 3'd4;

    typedef logic [GROUP_COUNT-1:0][15:0] group_array_t;

    typedef struct packed {
        group_array_t group_store;
        logic [3:0]   groups_taken;
        logic         gap_seen;
        logic [2:0]   gap_position;
        logic [15:0]  digit_accumulator;
        logic [2:0]   digits_in_group;
        logic         previous_was_colon;
        logic         error_seen;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '0;

    typedef struct packed {
        logic [7:0] text_char;
        logic       is_last;
    } char_item_t;

    typedef struct packed {
        logic        parse_ok;
        logic [63:0] address_upper;
        logic [63:0] address_lower;
    } result_item_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t hex_nibble(input logic [7:0] c);
        nibble_t    n;
        logic [7:0] diff;
        n    = '0;
        diff = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            diff = c - OFFSET_DIGIT;
            n.valid = 1'b1;
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            diff = c - OFFSET_LOWER;
            n.valid = 1'b1;
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            diff = c - OFFSET_UPPER;
            n.valid = 1'b1;
        end
        n.value = diff[3:0];
        return n;
    endfunction

endpackage

[rtl/ipv6tp_stream_if.sv]
// Interface: valid/ready stream channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface ipv6tp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/ipv6tp_char_step.sv]
// Character step: next parser state for one character, with final group closing.
`timescale 1ns / 1ps

module ipv6tp_char_step (
    input  ipv6tp_pkg::parse_state_t cur,
    input  logic [7:0]               text_char,
    input  logic                     is_last,
    output ipv6tp_pkg::parse_state_t nxt
);

    ipv6tp_pkg::nibble_t nib;

    assign nib = ipv6tp_pkg::hex_nibble(text_char);

    always_comb
    begin
        nxt = cur;
        if (!cur.error_seen && cur.groups_taken < ipv6tp_pkg::GROUPS_FULL)
        begin
            if (text_char == ipv6tp_pkg::CHAR_COLON)
            begin
                if (cur.digits_in_group != 3'd0)
                begin
                    nxt.group_store[cur.groups_taken[2:0]] = cur.digit_accumulator;
                    nxt.groups_taken       = cur.groups_taken + 4'd1;
                    nxt.digit_accumulator  = '0;
                    nxt.digits_in_group    = '0;
                    nxt.previous_was_colon = 1'b1;
                end
                else if (!cur.gap_seen)
                begin
                    nxt.gap_seen           = 1'b1;
                    nxt.gap_position       = cur.groups_taken[2:0];
                    nxt.previous_was_colon = 1'b1;
                end
                else if (cur.groups_taken == 4'd0 && cur.previous_was_colon)
                begin
                    nxt.previous_was_colon = 1'b0;
                end
                else
                begin
                    nxt.error_seen = 1'b1;
                end
            end
            else if (!nib.valid || cur.digits_in_group >= ipv6tp_pkg::DIGITS_FULL)
            begin
                nxt.error_seen = 1'b1;
            end
            else
            begin
                nxt.digit_accumulator  = {cur.digit_accumulator[11:0], nib.value};
                nxt.digits_in_group    = cur.digits_in_group + 3'd1;
                nxt.previous_was_colon = 1'b0;
            end
        end

        if (is_last && !nxt.error_seen && nxt.groups_taken < ipv6tp_pkg::GROUPS_FULL
            && nxt.digits_in_group != 3'd0)
        begin
            nxt.group_store[nxt.groups_taken[2:0]] = nxt.digit_accumulator;
            nxt.groups_taken      = nxt.groups_taken + 4'd1;
            nxt.digit_accumulator = '0;
            nxt.digits_in_group   = '0;
        end
    end

endmodule

[rtl/ipv6tp_expand.sv]
// Gap expansion: places stored groups around the zero gap and forms the result.
`timescale 1ns / 1ps

module ipv6tp_expand (
    input  ipv6tp_pkg::parse_state_t st,
    output ipv6tp_pkg::result_item_t res
);

    ipv6tp_pkg::group_array_t g;
    logic                     ok;
    logic                     expand;
    logic [3:0]               gp;
    logic [3:0]               tail;
    logic [3:0]               tail_start;

    assign ok     = !st.error_seen && (st.groups_taken == ipv6tp_pkg::GROUPS_FULL || st.gap_seen);
    assign expand = st.gap_seen && st.groups_taken < ipv6tp_pkg::GROUPS_FULL;
    assign gp     = ({1'b0, st.gap_position} > st.groups_taken) ? st.groups_taken
                                                                 : {1'b0, st.gap_position};
    assign tail       = st.groups_taken - gp;
    assign tail_start = ipv6tp_pkg::GROUPS_FULL - tail;

    always_comb
    begin
        logic [3:0] src;
        g   = '0;
        src = '0;
        for (int j = 0; j < ipv6tp_pkg::GROUP_COUNT; j++)
        begin
            src = 4'(j) + st.groups_taken - ipv6tp_pkg::GROUPS_FULL;
            if (!ok)
                g[j] = '0;
            else if (!expand)
                g[j] = st.group_store[j];
            else if (4'(j) < gp)
                g[j] = st.group_store[j];
            else if (4'(j) >= tail_start)
                g[j] = st.group_store[src[2:0]];
            else
                g[j] = '0;
        end
    end

    assign res.parse_ok      = ok;
    assign res.address_upper = {g[0], g[1], g[2], g[3]};
    assign res.address_lower = {g[4], g[5], g[6], g[7]};

endmodule

[rtl/ipv6tp_result_if_stub_unused.sv]
// Result register: holds one finished address until the downstream side takes it.
`timescale 1ns / 1ps

module ipv6tp_result_reg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  ipv6tp_pkg::result_item_t load_data,
    ipv6tp_stream_if.source          result_out
);

    logic                     valid_reg;
    logic                     valid_next;
    ipv6tp_pkg::result_item_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (result_out.ready)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign result_out.valid   = valid_reg;
    assign result_out.payload = data_reg;

endmodule

[rtl/ipv6_text_address_parser_core.sv]
// Top level: IPv6 text address parser, one character per transaction.
// The result is registered: it appears in the cycle after the last character is accepted.
// Throughput: one character per cycle while the result channel is not stalled.
// The accept path is the character step and gap expansion between state and result registers.
// Reset (rst_n low, asynchronous) clears the parser state and empties the result register.
`timescale 1ns / 1ps

module ipv6_text_address_parser_core (
    input  logic            clk,
    input  logic            rst_n,
    ipv6tp_stream_if.sink   text_in,
    ipv6tp_stream_if.source result_out
);

    ipv6tp_pkg::parse_state_t state_reg;
    ipv6tp_pkg::parse_state_t state_next;
    ipv6tp_pkg::parse_state_t step_state;
    ipv6tp_pkg::result_item_t final_result;
    ipv6tp_pkg::char_item_t   in_item;
    logic                     in_fire;
    logic                     load_result;

    assign in_item        = text_in.payload;
    assign text_in.ready  = !result_out.valid || result_out.ready;
    assign in_fire        = text_in.valid && text_in.ready;
    assign load_result    = in_fire && in_item.is_last;

    ipv6tp_char_step u_step (
        .cur       (state_reg),
        .text_char (in_item.text_char),
        .is_last   (in_item.is_last),
        .nxt       (step_state)
    );

    ipv6tp_expand u_expand (
        .st  (step_state),
        .res (final_result)
    );

    ipv6tp_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load_result),
        .load_data  (final_result),
        .result_out (result_out)
    );

    always_comb
    begin
        state_next = state_reg;
        if (in_fire)
        begin
            if (in_item.is_last)
                state_next = ipv6tp_pkg::PARSE_STATE_RESET;
            else
                state_next = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ipv6tp_pkg::PARSE_STATE_RESET;
        else
            state_reg <= state_next;
    end

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> result_out.valid)
        else $error("last character accepted without a result");

    a_fail_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.payload.parse_ok |->
        result_out.payload.address_upper == 64'd0 && result_out.payload.address_lower == 64'd0)
        else $error("failed parse carries a nonzero address");

    a_groups_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.groups_taken <= ipv6tp_pkg::GROUPS_FULL
        && state_reg.digits_in_group <= ipv6tp_pkg::DIGITS_FULL)
        else $error("group or digit count out of range");

    a_gap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.gap_seen |-> {1'b0, state_reg.gap_position} <= state_reg.groups_taken)
        else $error("gap position beyond stored groups");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> state_reg.groups_taken == 4'd0 && !state_reg.error_seen
        && !state_reg.gap_seen)
        else $error("parser state not cleared after last character");

endmodule
